/* rtl/core/cgt_pkg.sv */
`timescale 1ns / 1ps

package cgt_pkg;

  // Table geometry
  localparam int ENTRIES       = 16;
  localparam int SESSION_BYTES = 8;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ENTRIES + 1);

  // Operation codes
  localparam logic [1:0] OP_ISSUE   = 2'd0;
  localparam logic [1:0] OP_CONSUME = 2'd1;
  localparam logic [1:0] OP_REVOKE  = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_VALID_MASK = 1'b0;
  localparam logic CFG_CONS_MASK  = 1'b1;

  // One table entry; a key of zero marks a free entry
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] flags;
    logic [31:0] binding;
    logic [63:0] session;
  } slot_t;

  // One request as captured from the input channel
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [63:0] session;
    logic [31:0] flags;
    logic [31:0] binding;
  } req_t;

  // Commands from the sequencer to the slot store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_slot;
    logic             inv_one;
    logic [IDX_W-1:0] inv_addr;
    logic             clr_all;
  } mem_cmd_t;

  // Cut the session at its first zero byte
  function automatic logic [63:0] session_trim(input logic [63:0] tag);
    logic [63:0] res;
    logic        run;
    res = '0;
    run = 1'b1;
    for (int b = 0; b < 8; b++) begin
      run = run & (tag[8*b +: 8] != 8'd0);
      if (run) begin
        res[8*b +: 8] = tag[8*b +: 8];
      end
    end
    return res;
  endfunction

  // Session is nonempty and no longer than SESSION_BYTES
  function automatic logic session_len_ok(input logic [63:0] tag);
    logic run;
    logic too_long;
    run      = 1'b1;
    too_long = 1'b0;
    for (int b = 0; b < 8; b++) begin
      run = run & (tag[8*b +: 8] != 8'd0);
      if (b == SESSION_BYTES && run) begin
        too_long = 1'b1;
      end
    end
    return (tag[7:0] != 8'd0) && !too_long;
  endfunction

endpackage

/* rtl/core/cgt_slot_store.sv */
`timescale 1ns / 1ps

module cgt_slot_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgt_pkg::mem_cmd_t cmd_i,
  output cgt_pkg::slot_t    rd_slot_o
);

  cgt_pkg::slot_t                  mem_q [cgt_pkg::ENTRIES];
  logic [cgt_pkg::ENTRIES-1:0]     vld_q;
  cgt_pkg::slot_t                  rd_data_q;
  logic                            rd_hit_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= cmd_i.wr_slot;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_addr];
    end
  end

  // Track which entries hold a grant; reset and clear free every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (cmd_i.clr_all) begin
        vld_q <= '0;
      end else begin
        if (cmd_i.wr_en) begin
          vld_q[cmd_i.wr_addr] <= 1'b1;
        end
        if (cmd_i.inv_one) begin
          vld_q[cmd_i.inv_addr] <= 1'b0;
        end
      end
      if (cmd_i.rd_en) begin
        rd_hit_q <= vld_q[cmd_i.rd_addr];
      end
    end
  end

  // A free entry reads as all zero
  assign rd_slot_o = rd_hit_q ? rd_data_q : '0;

endmodule

/* rtl/core/cgt_engine.sv */
`timescale 1ns / 1ps

module cgt_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  cgt_pkg::req_t      req_i,
  input  logic [31:0]        valid_mask_i,
  input  logic [31:0]        cons_mask_i,
  input  logic               res_free_i,
  input  cgt_pkg::slot_t     rd_slot_i,
  output cgt_pkg::mem_cmd_t  cmd_o,
  output logic               done_o,
  output logic               ok_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [cgt_pkg::CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
  logic                         chk_vld_q, chk_vld_d;
  logic [cgt_pkg::IDX_W-1:0]    chk_idx_q, chk_idx_d;
  logic                         found_q, found_d;
  logic                         free_vld_q, free_vld_d;
  logic [cgt_pkg::IDX_W-1:0]    tgt_idx_q, tgt_idx_d;
  logic                         cons_ok_q, cons_ok_d;
  logic [31:0]                  new_flags_q, new_flags_d;
  logic                         pre_ok_q, pre_ok_d;

  logic [63:0] sess;
  logic        issue_pre;
  logic        consume_pre;
  logic        pre_ok;
  logic        scan_need;
  logic        key_eq;
  logic        sess_eq;
  logic        flag_granted;
  logic        bind_eq;
  logic        ok;
  cgt_pkg::slot_t new_slot;

  // Request checks that need no table access
  always_comb begin
    sess        = cgt_pkg::session_trim(req_i.session);
    issue_pre   = (req_i.key != '0) && (req_i.flags != '0) &&
                  ((req_i.flags & ~valid_mask_i) == '0) &&
                  cgt_pkg::session_len_ok(req_i.session);
    consume_pre = (req_i.key != '0) && (req_i.flags != '0) &&
                  ((req_i.flags & (req_i.flags - 32'd1)) == '0) &&
                  ((req_i.flags & cons_mask_i) != '0);
    case (req_i.op)
      cgt_pkg::OP_ISSUE: begin
        pre_ok    = issue_pre;
        scan_need = issue_pre;
      end
      cgt_pkg::OP_CONSUME: begin
        pre_ok    = consume_pre;
        scan_need = consume_pre;
      end
      cgt_pkg::OP_REVOKE: begin
        pre_ok    = 1'b1;
        scan_need = (req_i.key != '0);
      end
      default: begin
        pre_ok    = 1'b1;
        scan_need = 1'b0;
      end
    endcase
  end

  // Compare the entry read last cycle against the request
  assign key_eq       = (rd_slot_i.key == req_i.key);
  assign sess_eq      = (rd_slot_i.session == sess);
  assign flag_granted = ((rd_slot_i.flags & req_i.flags) != '0);
  assign bind_eq      = (rd_slot_i.binding == req_i.binding);

  // Entry written back by issue or consume
  always_comb begin
    new_slot.key     = req_i.key;
    new_slot.flags   = (req_i.op == cgt_pkg::OP_ISSUE) ? req_i.flags : new_flags_q;
    new_slot.binding = req_i.binding;
    new_slot.session = sess;
  end

  // Sequencer: scan every entry if the request needs a table search, then write back and report
  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    found_d     = found_q;
    free_vld_d  = free_vld_q;
    tgt_idx_d   = tgt_idx_q;
    cons_ok_d   = cons_ok_q;
    new_flags_d = new_flags_q;
    pre_ok_d    = pre_ok_q;
    cmd_o       = '0;
    done_o      = 1'b0;
    ok          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          found_d    = 1'b0;
          free_vld_d = 1'b0;
          cons_ok_d  = 1'b0;
          rd_cnt_d   = '0;
          pre_ok_d   = pre_ok;
          state_d    = scan_need ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (rd_cnt_q < cgt_pkg::CNT_W'(cgt_pkg::ENTRIES)) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = rd_cnt_q[cgt_pkg::IDX_W-1:0];
          rd_cnt_d      = rd_cnt_q + 1'b1;
          chk_vld_d     = 1'b1;
          chk_idx_d     = rd_cnt_q[cgt_pkg::IDX_W-1:0];
        end
        // check the entry that came back
        if (chk_vld_q) begin
          case (req_i.op)
            cgt_pkg::OP_ISSUE: begin
              if (key_eq) begin
                found_d = 1'b1;
              end
              if (rd_slot_i.key == '0 && !free_vld_q) begin
                free_vld_d = 1'b1;
                tgt_idx_d  = chk_idx_q;
              end
            end
            cgt_pkg::OP_CONSUME: begin
              if (key_eq && sess_eq && !found_q) begin
                found_d     = 1'b1;
                tgt_idx_d   = chk_idx_q;
                cons_ok_d   = flag_granted && bind_eq;
                new_flags_d = rd_slot_i.flags & ~req_i.flags;
              end
            end
            cgt_pkg::OP_REVOKE: begin
              if (key_eq) begin
                cmd_o.inv_one  = 1'b1;
                cmd_o.inv_addr = chk_idx_q;
              end
            end
            default: ;
          endcase
          if (chk_idx_q == cgt_pkg::IDX_W'(cgt_pkg::ENTRIES - 1)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (res_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
          case (req_i.op)
            cgt_pkg::OP_ISSUE: begin
              ok = pre_ok_q && !found_q && free_vld_q;
              if (ok) begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_addr = tgt_idx_q;
                cmd_o.wr_slot = new_slot;
              end
            end
            cgt_pkg::OP_CONSUME: begin
              ok = pre_ok_q && found_q && cons_ok_q;
              if (ok) begin
                if (new_flags_q == '0) begin
                  cmd_o.inv_one  = 1'b1;
                  cmd_o.inv_addr = tgt_idx_q;
                end else begin
                  cmd_o.wr_en   = 1'b1;
                  cmd_o.wr_addr = tgt_idx_q;
                  cmd_o.wr_slot = new_slot;
                end
              end
            end
            cgt_pkg::OP_REVOKE: begin
              ok = 1'b1;
            end
            default: begin
              ok            = 1'b1;
              cmd_o.clr_all = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ok_o = ok;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  // Scan results
  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    found_q     <= found_d;
    free_vld_q  <= free_vld_d;
    tgt_idx_q   <= tgt_idx_d;
    cons_ok_q   <= cons_ok_d;
    new_flags_q <= new_flags_d;
    pre_ok_q    <= pre_ok_d;
  end

endmodule

/* rtl/core/capability_grant_table_core.sv */
`timescale 1ns / 1ps

// Table of one-shot permission grants (issue, consume, revoke, clear all).
// Input channel: in_valid_i / in_ready_o with op_i, request_key_i,
// session_tag_i, flag_bits_i and binding_value_i; a transfer happens when
// both are high. Output channel: out_valid_o / out_ready_i with ok_o, one
// result per request, in request order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 valid flag mask, 1 consumable flag mask) at once; write only while idle.
// Issue, consume and nonzero-key revoke scan all ENTRIES table
// entries through the single read port of the slot store, one per cycle,
// before the result is produced. Requests rejected by the field checks,
// clear all and zero-key revoke skip the scan and go straight to the
// result. One request is processed at a time.
// A new request is taken while the previous result waits at the output.
// If the receiver stalls, the result holds in the output register and the
// table waits before writing back, so nothing is lost.
// Reset frees every entry at once and sets both masks to 3.
module capability_grant_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] request_key_i,
  input  logic [63:0] session_tag_i,
  input  logic [31:0] flag_bits_i,
  input  logic [31:0] binding_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o
);

  logic [31:0]       valid_mask_q;
  logic [31:0]       cons_mask_q;
  cgt_pkg::req_t     req_q;
  logic              req_pend_q;
  logic              out_valid_q;
  logic              ok_q;
  logic              in_xfer;
  logic              res_free;
  logic              done;
  logic              eng_ok;
  cgt_pkg::mem_cmd_t cmd;
  cgt_pkg::slot_t    rd_slot;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_mask_q <= 32'd3;
      cons_mask_q  <= 32'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cgt_pkg::CFG_VALID_MASK: valid_mask_q <= cfg_wdata_i;
        cgt_pkg::CFG_CONS_MASK:  cons_mask_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !req_pend_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign res_free   = !out_valid_q || out_ready_i;

  // Hold the request until its result is produced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_pend_q <= 1'b0;
    end else if (in_xfer) begin
      req_pend_q <= 1'b1;
    end else if (done) begin
      req_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.op      <= op_i;
      req_q.key     <= request_key_i;
      req_q.session <= session_tag_i;
      req_q.flags   <= flag_bits_i;
      req_q.binding <= binding_value_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      ok_q <= eng_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;

  cgt_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_pend_q),
    .req_i        (req_q),
    .valid_mask_i (valid_mask_q),
    .cons_mask_i  (cons_mask_q),
    .res_free_i   (res_free),
    .rd_slot_i    (rd_slot),
    .cmd_o        (cmd),
    .done_o       (done),
    .ok_o         (eng_ok)
  );

  cgt_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_slot_o (rd_slot)
  );

endmodule
